@@ hw/rtl/krt_pkg.sv @@
// Shared constants and types for the keyed record table.
`timescale 1ns / 1ps

package krt_pkg;

    // default number of records held
    localparam int CAPACITY_DEF = 16;

    // field widths
    localparam int KEY_W   = 8;
    localparam int REC_W   = 64;    // key, year, three item ids, three grades
    localparam int DATA_W  = 56;    // record without its key
    localparam int POS_W   = 4;
    localparam int KIND_W  = 3;
    localparam int IN_W    = 72;    // 64 record bits + 4 position bits, byte padded

    // bit offset of the position field in the request data
    localparam int POS_LSB = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_LOOKUP = 3'd2,
        KIND_EXISTS = 3'd3,
        KIND_READ   = 3'd4
    } t_kind;

endpackage

@@ hw/rtl/keyed_record_table.sv @@
// Keyed record table: packed record store with append, remove, lookup, exists and read.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_*): one request per handshake. s_tuser carries the operation
//   kind, s_tdata the record (key lowest) and the read position.
//   Master stream (m_*): one response per request, in order. m_tuser carries ok,
//   m_tdata the read key, the found record's remaining bytes, the count and full.
//   Records live in a single-port-per-direction memory (one write, one registered
//   read per cycle); one key comparator and one index counter serve every search.
//   Sequence from the accepting edge to response valid:
//     append, unused kinds, out-of-range read : straight to the response stage
//     read by position                        : one registered memory read
//     lookup / exists                         : search that stops at the first hit
//     remove                                  : full search, then compaction of the
//                                               records behind the hit (none for last)
//   s_tready rises with response valid.
//   The response sits in an output register, so the next request is taken while
//   a response still waits; if the receiver stalls longer, the finished response
//   of the following request is held until the register frees.
//   Reset (synchronous, i_rst_n low) empties the table and drops any response.
//   Record memory contents are not cleared: slots past the count are never read.
module keyed_record_table #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [7:0] key, [15:8] year, [23:16] course_id_0, [31:24] course_id_1,
    // [39:32] course_id_2, [47:40] grade_0, [55:48] grade_1, [63:56] grade_2,
    // [67:64] position, [71:68] zero
    input  logic [krt_pkg::IN_W-1:0]    s_tdata,
    // [2:0] kind
    input  logic [krt_pkg::KIND_W-1:0]  s_tuser,
    // response stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] key_out, [15:8] year_out, [23:16] course_out_0, [31:24] course_out_1,
    // [39:32] course_out_2, [47:40] grade_out_0, [55:48] grade_out_1,
    // [63:56] grade_out_2, then entry_count, then is_full, then zero padding
    output logic [(((64 + $clog2(CAPACITY + 1) + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    // [0] ok
    output logic [0:0]                  m_tuser
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > krt_pkg::POS_W) ? CNT_W : krt_pkg::POS_W;
    localparam int OUT_USE = krt_pkg::REC_W + CNT_W + 1;
    localparam int OUT_W   = ((OUT_USE + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READ,
        S_DONE
    } t_state;

    // record memory
    logic [krt_pkg::REC_W-1:0] mem [CAPACITY];
    logic [krt_pkg::REC_W-1:0] r_rdata;
    logic                      w_we;
    logic [IDX_W-1:0]          w_waddr;
    logic [IDX_W-1:0]          w_raddr;
    logic [krt_pkg::REC_W-1:0] w_wdata;

    // sequencer state
    t_state                     r_state,  n_state;
    logic [CNT_W-1:0]           r_count,  n_count;
    logic [CNT_W-1:0]           r_idx,    n_idx;     // next entry to read
    logic                       r_rd_vld, n_rd_vld;  // r_rdata holds entry r_rd_idx
    logic [CNT_W-1:0]           r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]           r_hit,    n_hit;
    logic                       r_found,  n_found;
    krt_pkg::t_kind             r_kind,   n_kind;
    logic [krt_pkg::KEY_W-1:0]  r_key,    n_key;
    // staged response
    logic                       r_ok,     n_ok;
    logic [krt_pkg::KEY_W-1:0]  r_keyo,   n_keyo;
    logic [krt_pkg::DATA_W-1:0] r_data,   n_data;
    // output register
    logic                       r_mvalid, n_mvalid;
    logic [OUT_W-1:0]           r_mdata,  n_mdata;
    logic [0:0]                 r_muser,  n_muser;

    logic             w_issue;
    logic             w_match;
    logic [CNT_W-1:0] w_prev;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt_ext;
    logic [OUT_W-1:0] w_pack;

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;

    // shared compare unit and index arithmetic
    assign w_issue   = (r_idx < r_count);
    assign w_match   = r_rd_vld && (r_rdata[krt_pkg::KEY_W-1:0] == r_key);
    assign w_prev    = CNT_W'(r_rd_idx - 1'b1);
    assign w_pos     = CMP_W'(s_tdata[krt_pkg::POS_LSB +: krt_pkg::POS_W]);
    assign w_cnt_ext = CMP_W'(r_count);

    always_comb begin
        w_pack = '0;
        w_pack[krt_pkg::KEY_W-1:0]              = r_keyo;
        w_pack[krt_pkg::REC_W-1:krt_pkg::KEY_W] = r_data;
        w_pack[krt_pkg::REC_W +: CNT_W]         = r_count;
        w_pack[krt_pkg::REC_W + CNT_W]          = (r_count == CNT_W'(CAPACITY));
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_rd_vld = r_rd_vld;
        n_rd_idx = r_rd_idx;
        n_hit    = r_hit;
        n_found  = r_found;
        n_kind   = r_kind;
        n_key    = r_key;
        n_ok     = r_ok;
        n_keyo   = r_keyo;
        n_data   = r_data;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        n_muser  = r_muser;
        w_we     = 1'b0;
        w_waddr  = r_count[IDX_W-1:0];
        w_wdata  = s_tdata[krt_pkg::REC_W-1:0];
        w_raddr  = r_idx[IDX_W-1:0];

        if (r_mvalid && m_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_kind   = krt_pkg::t_kind'(s_tuser);
                    n_key    = s_tdata[krt_pkg::KEY_W-1:0];
                    n_ok     = 1'b0;
                    n_keyo   = '0;
                    n_data   = '0;
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_found  = 1'b0;
                    n_hit    = '0;
                    unique case (krt_pkg::t_kind'(s_tuser))
                        krt_pkg::KIND_APPEND: begin
                            if (r_count < CNT_W'(CAPACITY)) begin
                                w_we    = 1'b1;
                                n_count = CNT_W'(r_count + 1'b1);
                                n_ok    = 1'b1;
                            end
                            n_state = S_DONE;
                        end
                        krt_pkg::KIND_REMOVE,
                        krt_pkg::KIND_LOOKUP,
                        krt_pkg::KIND_EXISTS: begin
                            n_state = S_SCAN;
                        end
                        krt_pkg::KIND_READ: begin
                            // in range implies below CAPACITY, so the cut is exact
                            w_raddr = IDX_W'(w_pos);
                            if (w_pos < w_cnt_ext) begin
                                n_state = S_READ;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // one read issued per cycle, its key compared the cycle after
                n_rd_vld = w_issue;
                n_rd_idx = r_idx;
                if (w_issue) begin
                    n_idx = CNT_W'(r_idx + 1'b1);
                end
                if (w_match && (r_kind != krt_pkg::KIND_REMOVE)) begin
                    n_ok     = 1'b1;
                    n_rd_vld = 1'b0;
                    if (r_kind == krt_pkg::KIND_LOOKUP) begin
                        n_data = r_rdata[krt_pkg::REC_W-1:krt_pkg::KEY_W];
                    end
                    n_state = S_DONE;
                end else begin
                    // remove keeps the last hit
                    if (w_match) begin
                        n_found = 1'b1;
                        n_hit   = r_rd_idx;
                    end
                    if (!w_issue && !r_rd_vld) begin
                        if (r_found) begin
                            n_idx   = CNT_W'(r_hit + 1'b1);
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end

            S_SHIFT: begin
                // read entry j+1, write it to j on the next cycle
                n_rd_vld = w_issue;
                n_rd_idx = r_idx;
                if (w_issue) begin
                    n_idx = CNT_W'(r_idx + 1'b1);
                end
                if (r_rd_vld) begin
                    w_we    = 1'b1;
                    w_waddr = w_prev[IDX_W-1:0];
                    w_wdata = r_rdata;
                end
                if (!w_issue && !r_rd_vld) begin
                    n_count = CNT_W'(r_count - 1'b1);
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_READ: begin
                n_ok    = 1'b1;
                n_keyo  = r_rdata[krt_pkg::KEY_W-1:0];
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_mvalid || m_tready) begin
                    n_mvalid   = 1'b1;
                    n_mdata    = w_pack;
                    n_muser[0] = r_ok;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
            r_found  <= n_found;
            r_mvalid <= n_mvalid;
        end
        r_rd_idx <= n_rd_idx;
        r_hit    <= n_hit;
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_ok     <= n_ok;
        r_keyo   <= n_keyo;
        r_data   <= n_data;
        r_mdata  <= n_mdata;
        r_muser  <= n_muser;
    end

    // record memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

endmodule

@@ verif/tb_keyed_record_table.sv @@
// Self-checking testbench for the keyed record table: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_keyed_record_table;

    localparam int CAP         = krt_pkg::CAPACITY_DEF;
    localparam int KIND_W      = krt_pkg::KIND_W;
    localparam int REC_W       = krt_pkg::REC_W;
    localparam int POS_W       = krt_pkg::POS_W;
    localparam int KEY_W       = krt_pkg::KEY_W;
    localparam int DATA_W      = krt_pkg::DATA_W;
    localparam int IN_W        = krt_pkg::IN_W;
    localparam int POS_LSB     = krt_pkg::POS_LSB;
    localparam int CNT_W       = $clog2(CAP + 1);
    localparam int OUT_W       = (((64 + CNT_W + 1) + 7) / 8) * 8;

    // kinds the block does no work for; each must still answer with ok low
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam int RANDOM_N    = 1380;
    localparam int CYCLE_LIMIT = 1_000_000;
    // worst request: remove with a full search and a full compaction
    localparam int SETTLE_WAIT = 2 * CAP + 20;
    localparam int HOLD_AT     = 300;   // responses taken before the long hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int PAUSE_AT    = 700;   // random request at which the sender drains
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [REC_W-1:0]  rec;     // key in the lowest byte
        logic [POS_W-1:0]  pos;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [KEY_W-1:0]  key_out;
        logic [DATA_W-1:0] found;   // year, three item ids, three grades
        logic [CNT_W-1:0]  count;
        logic              full;
    } t_resp;

    typedef struct packed {
        t_req              req;
        logic [7:0]        rep;     // repeats, key stepped by one each time
        logic              typed;   // use the written response, not the predictor's
        t_resp             want;
    } t_plan_row;

    localparam int PLAN_N = 22;

    // Directed requests. Rows marked typed carry a response that is plain from
    // the table's contents at that point; the rest go through the predictor.
    localparam t_plan_row PLAN [PLAN_N] = '{
        // empty table: every search misses, read is out of range
        '{'{krt_pkg::KIND_EXISTS, 64'h0,                   4'h0}, 8'd1,  1'b1,
          '{1'b0, 8'h00, 56'h0, 5'd0, 1'b0}},
        '{'{krt_pkg::KIND_REMOVE, 64'hFF,                  4'h0}, 8'd1,  1'b1,
          '{1'b0, 8'h00, 56'h0, 5'd0, 1'b0}},
        '{'{krt_pkg::KIND_READ,   64'h0,                   4'h0}, 8'd1,  1'b1,
          '{1'b0, 8'h00, 56'h0, 5'd0, 1'b0}},
        '{'{krt_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF}, 8'd1,  1'b1,
          '{1'b0, 8'h00, 56'h0, 5'd0, 1'b0}},
        '{'{KIND_SPARE_HI,        64'hFFFF_FFFF_FFFF_FFFF, 4'hF}, 8'd1,  1'b1,
          '{1'b0, 8'h00, 56'h0, 5'd0, 1'b0}},
        // all-zero and all-ones records
        '{'{krt_pkg::KIND_APPEND, 64'h0,                   4'h0}, 8'd1,  1'b1,
          '{1'b1, 8'h00, 56'h0, 5'd1, 1'b0}},
        '{'{krt_pkg::KIND_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF}, 8'd1,  1'b1,
          '{1'b1, 8'h00, 56'h0, 5'd2, 1'b0}},
        '{'{krt_pkg::KIND_LOOKUP, 64'hFF,                  4'h0}, 8'd1,  1'b1,
          '{1'b1, 8'h00, 56'hFF_FFFF_FFFF_FFFF, 5'd2, 1'b0}},
        '{'{krt_pkg::KIND_READ,   64'h0,                   4'hF}, 8'd1,  1'b1,
          '{1'b0, 8'h00, 56'h0, 5'd2, 1'b0}},
        '{'{krt_pkg::KIND_READ,   64'h0,                   4'h1}, 8'd1,  1'b1,
          '{1'b1, 8'hFF, 56'h0, 5'd2, 1'b0}},
        // duplicate key: lookup takes the first, remove the last
        '{'{krt_pkg::KIND_APPEND, 64'h0123_4567_89AB_CDFF, 4'h0}, 8'd1,  1'b0, '0},
        '{'{krt_pkg::KIND_LOOKUP, 64'hFF,                  4'h0}, 8'd1,  1'b0, '0},
        '{'{krt_pkg::KIND_REMOVE, 64'hFF,                  4'h0}, 8'd1,  1'b0, '0},
        '{'{krt_pkg::KIND_EXISTS, 64'hFF,                  4'h0}, 8'd1,  1'b0, '0},
        '{'{KIND_SPARE_LO,        64'h5A,                  4'h3}, 8'd1,  1'b0, '0},
        // fill to capacity, then one append too many
        '{'{krt_pkg::KIND_APPEND, 64'hA55A_3CC3_0FF0_9610, 4'h0}, 8'd14, 1'b0, '0},
        '{'{krt_pkg::KIND_APPEND, 64'h80,                  4'h0}, 8'd1,  1'b1,
          '{1'b0, 8'h00, 56'h0, 5'd16, 1'b1}},
        '{'{krt_pkg::KIND_READ,   64'h0,                   4'hF}, 8'd1,  1'b0, '0},
        // removing the head record shifts the whole table down
        '{'{krt_pkg::KIND_REMOVE, 64'h00,                  4'h0}, 8'd1,  1'b0, '0},
        '{'{krt_pkg::KIND_EXISTS, 64'h00,                  4'h0}, 8'd1,  1'b0, '0},
        '{'{krt_pkg::KIND_REMOVE, 64'hAB,                  4'h0}, 8'd1,  1'b0, '0},
        '{'{krt_pkg::KIND_READ,   64'h0,                   4'hE}, 8'd1,  1'b0, '0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // [63:0] record (key lowest), [67:64] position, [71:68] zero
    logic [IN_W-1:0]   s_tdata;
    // [2:0] kind
    logic [KIND_W-1:0] s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    // [7:0] key_out, [63:8] found record, then entry_count, is_full, zero padding
    logic [OUT_W-1:0]  m_tdata;
    // [0] ok
    logic [0:0]        m_tuser;

    // predictor's own copy of the table
    logic [REC_W-1:0]  shadow_rec [CAP];
    int                shadow_held;

    t_resp             pending [$];     // responses owed, oldest first
    logic [KEY_W-1:0]  key_pool [8];    // small key set so that searches hit
    int                errors    = 0;
    int                sent      = 0;
    int                cycle_cnt = 0;
    bit                tx_calm   = 0;
    bit                rx_calm   = 0;

    keyed_record_table #(
        .CAPACITY (CAP)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // hard stop should the block hang
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Applies one request to the shadow table and returns the response owed.
    function automatic t_resp table_apply(t_req r);
        t_resp            res;
        int               hit;
        logic [KEY_W-1:0] key;
        res = '0;
        hit = -1;
        key = r.rec[KEY_W-1:0];
        unique case (r.kind)
            krt_pkg::KIND_APPEND: begin
                if (shadow_held < CAP) begin
                    shadow_rec[shadow_held] = r.rec;
                    shadow_held++;
                    res.ok = 1'b1;
                end
            end
            krt_pkg::KIND_REMOVE: begin
                // last match goes; later records close the gap
                for (int m = 0; m < shadow_held; m++)
                    if (shadow_rec[m][KEY_W-1:0] == key) hit = m;
                if (hit >= 0) begin
                    for (int j = hit; j + 1 < shadow_held; j++)
                        shadow_rec[j] = shadow_rec[j + 1];
                    shadow_held--;
                    res.ok = 1'b1;
                end
            end
            krt_pkg::KIND_LOOKUP, krt_pkg::KIND_EXISTS: begin
                // scan downwards so the first match is the one kept
                for (int m = shadow_held - 1; m >= 0; m--)
                    if (shadow_rec[m][KEY_W-1:0] == key) hit = m;
                if (hit >= 0) begin
                    res.ok = 1'b1;
                    if (r.kind == krt_pkg::KIND_LOOKUP)
                        res.found = shadow_rec[hit][REC_W-1:KEY_W];
                end
            end
            krt_pkg::KIND_READ: begin
                if (int'(r.pos) < shadow_held) begin
                    res.ok      = 1'b1;
                    res.key_out = shadow_rec[r.pos][KEY_W-1:0];
                end
            end
            default: ;
        endcase
        res.count = CNT_W'(shadow_held);
        res.full  = (shadow_held == CAP);
        return res;
    endfunction

    function automatic void report_failure(string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            report_failure($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
    endfunction

    // Random request: phases of filling and draining keep the count moving
    // between empty and full so that both ends get exercised.
    function automatic t_req random_request(int idx);
        t_req r;
        int   roll;
        bit   filling;
        filling = ((idx / 90) % 2) == 0;
        roll    = $urandom_range(0, 99);
        r.rec   = {$urandom, $urandom};
        r.pos   = POS_W'($urandom_range(0, 15));
        if ($urandom_range(0, 4) != 0) r.rec[KEY_W-1:0] = key_pool[$urandom_range(0, 7)];
        if (roll < (filling ? 55 : 20))      r.kind = krt_pkg::KIND_APPEND;
        else if (roll < (filling ? 65 : 55)) r.kind = krt_pkg::KIND_REMOVE;
        else if (roll < (filling ? 80 : 72)) r.kind = krt_pkg::KIND_LOOKUP;
        else if (roll < (filling ? 88 : 82)) r.kind = krt_pkg::KIND_EXISTS;
        else if (roll < (filling ? 96 : 94)) r.kind = krt_pkg::KIND_READ;
        else r.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        // most reads land inside the table
        if (r.kind == krt_pkg::KIND_READ && shadow_held > 0 && $urandom_range(0, 3) != 0)
            r.pos = POS_W'($urandom_range(0, shadow_held - 1));
        return r;
    endfunction

    // Offers one request after a random gap; the owed response is worked out at
    // the handshake. Valid stays high when the next gap is zero.
    task automatic offer_request(t_req r, logic typed, t_resp want);
        int    gap;
        t_resp owed;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - POS_LSB - POS_W){1'b0}}, r.pos, r.rec};
        s_tuser  <= r.kind;
        do @(posedge i_clk); while (!s_tready);
        owed = table_apply(r);
        pending.push_back(typed ? want : owed);
        sent++;
        if (sent % 64 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    endtask

    // Sender stops and waits for every owed response.
    task automatic drain_responses();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending.size() != 0);
    endtask

    // Sender side and end of run.
    initial begin : feed_side
        t_req r;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        shadow_held = 0;
        foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
        key_pool[0] = 8'h00;
        key_pool[7] = 8'hFF;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PLAN[i]) begin
            for (int n = 0; n < PLAN[i].rep; n++) begin
                r = PLAN[i].req;
                r.rec[KEY_W-1:0] = r.rec[KEY_W-1:0] + KEY_W'(n);
                offer_request(r, PLAN[i].typed, PLAN[i].want);
            end
        end
        drain_responses();

        for (int i = 0; i < RANDOM_N; i++) begin
            if (i == PAUSE_AT) drain_responses();
            r = random_request(i);
            offer_request(r, 1'b0, '0);
        end

        drain_responses();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (errors == 0 && pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver side: random stalls, one long hold-off so the block backs up.
    initial begin : drain_side
        int    stall;
        int    seen;
        t_resp got;
        t_resp want;
        seen = 0;
        m_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 19);
            if (seen == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
            got.ok      = m_tuser[0];
            got.key_out = m_tdata[KEY_W-1:0];
            got.found   = m_tdata[REC_W-1:KEY_W];
            got.count   = m_tdata[REC_W +: CNT_W];
            got.full    = m_tdata[REC_W + CNT_W];
            if (pending.size() == 0) begin
                report_failure($sformatf("response with no request owed: %h", got));
            end else begin
                want = pending.pop_front();
                field_check("ok", 64'(want.ok), 64'(got.ok));
                field_check("key_out", 64'(want.key_out), 64'(got.key_out));
                for (int k = 0; k < DATA_W / 8; k++)
                    field_check($sformatf("record byte %0d", k + 1),
                                64'(want.found[8*k +: 8]), 64'(got.found[8*k +: 8]));
                field_check("entry_count", 64'(want.count), 64'(got.count));
                field_check("is_full", 64'(want.full), 64'(got.full));
            end
            seen++;
            if (seen % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        end
    end

endmodule
